// ===== src/kmerrd_pkg.sv =====
// kmerrd_pkg: shared types, constants and base coding for the k-mer repeat detector
package kmerrd_pkg;

  localparam int unsigned CntW      = 2;
  localparam int unsigned EpochW    = 6;
  localparam int unsigned SeenW     = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharG = 8'h47;
  localparam logic [7:0] CharT = 8'h54;

  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  localparam logic [CntW-1:0] CntOne = 2'd1;
  localparam logic [CntW-1:0] CntSat = 2'd3;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    unique case (ch)
      CharC:   code = CodeC;
      CharG:   code = CodeG;
      CharT:   code = CodeT;
      default: code = CodeA;
    endcase
    return code;
  endfunction

endpackage

// ===== src/kmer_repeat_detector_top.sv =====
// kmer_repeat_detector_top: rolling 2-bit k-mer key with a count store and repeat reporting
// a result is registered in the read stage, then queued, before it reaches the output
// throughput: one base per cycle unless stalled; counted bases do a store read-modify-write
// reset: a clearing pass writes all 2**(2*KMER_LENGTH) count entries before bases
// are taken; the same pass runs again after every 64th sequence end (epoch tag wrap)
// the 6-bit epoch tag on each entry stands in for clearing the store between sequences
module kmer_repeat_detector_top
  import kmerrd_pkg::*;
#(
  parameter int unsigned KMER_LENGTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               base_char_i,
  input  logic                     last_base_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2*KMER_LENGTH-1:0] kmer_code_o,
  output logic                     repeat_found_o,
  output logic                     sequence_end_o
);

  localparam int unsigned KeyBits    = 2 * KMER_LENGTH;
  localparam int unsigned StoreDepth = 2 ** KeyBits;
  localparam int unsigned EntW       = EpochW + CntW;

  // sequence state
  state_e              state_q, state_d;
  logic [KeyBits-1:0]  key_q, key_d;
  logic [SeenW-1:0]    seen_q, seen_d;
  logic [EpochW-1:0]   epoch_q, epoch_d;
  logic [KeyBits-1:0]  clr_addr_q, clr_addr_d;

  // read stage
  logic                s1_valid_q;
  logic [KeyBits-1:0]  s1_key_q;
  logic                s1_count_q;
  logic                s1_last_q;
  logic [EpochW-1:0]   s1_epoch_q;

  // last write, for the read that overlapped it
  logic                fwd_valid_q;
  logic [KeyBits-1:0]  fwd_key_q;
  logic [CntW-1:0]     fwd_cnt_q;
  logic [EpochW-1:0]   fwd_epoch_q;

  // count store
  logic [EntW-1:0]     count_mem [StoreDepth];
  logic [EntW-1:0]     rdata_q;
  logic                mem_we;
  logic [KeyBits-1:0]  mem_waddr;
  logic [EntW-1:0]     mem_wdata;

  // result queue
  logic [KeyBits-1:0]  fifo_key_q   [FifoDepth];
  logic                fifo_found_q [FifoDepth];
  logic                fifo_end_q   [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] fifo_cnt_q;

  logic                in_acc;
  logic                out_acc;
  logic                clr_we;
  logic                s1_we;
  logic [CntW-1:0]     cur_cnt;
  logic [CntW-1:0]     new_cnt;
  logic                found;
  logic                push;
  logic [FifoCntW-1:0] pending;
  logic                count_en_d;

  assign pending    = fifo_cnt_q + FifoCntW'(s1_valid_q);
  assign in_ready_o = (state_q == ST_RUN) && (pending < FifoCntW'(FifoDepth));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_acc    = out_valid_o && out_ready_i;

  // next key and base count for the accepted base
  always_comb begin
    logic [KeyBits-1:0] shifted;
    logic [KeyBits-1:0] code_top;
    shifted    = key_q >> 2;
    code_top   = KeyBits'(base_code(base_char_i)) << (KeyBits - 2);
    key_d      = shifted | code_top;
    seen_d     = (seen_q < SeenW'(KMER_LENGTH)) ? seen_q + SeenW'(1) : seen_q;
    count_en_d = (seen_d == SeenW'(KMER_LENGTH));
  end

  // state machine: clearing pass and epoch
  always_comb begin
    state_d    = state_q;
    epoch_d    = epoch_q;
    clr_addr_d = clr_addr_q;
    clr_we     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_we = !s1_valid_q;
        if (clr_we) begin
          clr_addr_d = clr_addr_q + KeyBits'(1);
          if (clr_addr_q == '1) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (in_acc && last_base_i) begin
          if (epoch_q == '1) begin
            epoch_d    = '0;
            clr_addr_d = '0;
            state_d    = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + EpochW'(1);
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      epoch_q    <= '0;
      clr_addr_q <= '0;
      key_q      <= '0;
      seen_q     <= '0;
    end else begin
      state_q    <= state_d;
      epoch_q    <= epoch_d;
      clr_addr_q <= clr_addr_d;
      if (in_acc) begin
        if (last_base_i) begin
          key_q  <= '0;
          seen_q <= '0;
        end else begin
          key_q  <= key_d;
          seen_q <= seen_d;
        end
      end
    end
  end

  // read stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_key_q   <= key_d;
      s1_count_q <= count_en_d;
      s1_last_q  <= last_base_i;
      s1_epoch_q <= epoch_q;
    end
  end

  // count store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= count_mem[key_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
  end

  // modify: stale epoch reads as zero, overlapping write wins
  always_comb begin
    logic [EpochW-1:0] rd_epoch;
    logic [CntW-1:0]   rd_cnt;
    rd_epoch = rdata_q[CntW +: EpochW];
    rd_cnt   = rdata_q[CntW-1:0];
    if (fwd_valid_q && (fwd_key_q == s1_key_q) && (fwd_epoch_q == s1_epoch_q)) begin
      cur_cnt = fwd_cnt_q;
    end else if (rd_epoch == s1_epoch_q) begin
      cur_cnt = rd_cnt;
    end else begin
      cur_cnt = '0;
    end
    new_cnt = (cur_cnt == CntSat) ? CntSat : cur_cnt + CntW'(1);
  end

  assign s1_we     = s1_valid_q && s1_count_q;
  assign found     = s1_we && (cur_cnt == CntOne);
  assign push      = s1_valid_q && (found || s1_last_q);
  assign mem_we    = clr_we || s1_we;
  assign mem_waddr = clr_we ? clr_addr_q : s1_key_q;
  assign mem_wdata = clr_we ? '0 : {s1_epoch_q, new_cnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      fwd_key_q   <= s1_key_q;
      fwd_cnt_q   <= new_cnt;
      fwd_epoch_q <= s1_epoch_q;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_key_q[wr_ptr_q]   <= found ? s1_key_q : '0;
      fifo_found_q[wr_ptr_q] <= found;
      fifo_end_q[wr_ptr_q]   <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push) - FifoCntW'(out_acc);
    end
  end

  assign kmer_code_o    = fifo_key_q[rd_ptr_q];
  assign repeat_found_o = fifo_found_q[rd_ptr_q];
  assign sequence_end_o = fifo_end_q[rd_ptr_q];

endmodule

// ===== src/kmerrd_checker.sv =====
// kmerrd_checker: port-level checks for the k-mer repeat detector, bound to the top level
module kmerrd_checker #(
  parameter int unsigned KMER_LENGTH = 10
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2*KMER_LENGTH-1:0] kmer_code_o,
  input logic                     repeat_found_o,
  input logic                     sequence_end_o
);

  // every result is a repeat, a sequence end or both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_found_o || sequence_end_o))
    else $error("result with neither repeat nor sequence end");

  // an end-only result carries a zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !repeat_found_o) |-> (kmer_code_o == '0))
    else $error("non-zero code without a repeat");

  // an empty output stays empty unless a request was accepted in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !$past(in_valid_i && in_ready_o)) |=> !out_valid_o ||
      $past(in_valid_i && in_ready_o, 2))
    else $error("result without a request");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(kmer_code_o) &&
      $stable(repeat_found_o) && $stable(sequence_end_o)))
    else $error("stalled result changed");

endmodule

bind kmer_repeat_detector_top kmerrd_checker #(
  .KMER_LENGTH(KMER_LENGTH)
) u_kmerrd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kmer_code_o    (kmer_code_o),
  .repeat_found_o (repeat_found_o),
  .sequence_end_o (sequence_end_o)
);
